// File: design/ipd_pkg.sv
package ipd_pkg;

  localparam int unsigned PrefixLen = 7;
  localparam logic [7:0]  DigitBase = 8'h30;
  localparam logic [7:0]  ColonChar = 8'h3A;
  localparam int unsigned CountFieldMax = 2047;
  localparam int unsigned LenW = 11;

  // status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StBadHeader = 2'd1;
  localparam logic [1:0] StNoColon   = 2'd2;
  localparam logic [1:0] StMismatch  = 2'd3;

  // token queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    TK_NONE,
    TK_DIGIT,
    TK_PAYLOAD
  } tok_kind_e;

  // how a last word closes the message
  typedef enum logic [1:0] {
    CL_BAD,
    CL_NOCOLON,
    CL_CHECK
  } end_cls_e;

  typedef struct packed {
    logic [7:0] data;
    tok_kind_e  kind;
    logic       last;
    end_cls_e   cls;
  } ipd_tok_t;

  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h0D;
      3'd1:    b = 8'h0A;
      3'd2:    b = 8'h2B;
      3'd3:    b = 8'h49;
      3'd4:    b = 8'h50;
      3'd5:    b = 8'h44;
      3'd6:    b = 8'h2C;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/ipd_frame_header_parser_top.sv
// Channel | Dir | Handshake               | Fields
// --------+-----+-------------------------+---------------------------------------------
// in      | in  | in_valid_i / in_ready_o | data_byte_i, last_i
// out     | out | out_valid_o/out_ready_i | payload_byte_o, payload_valid_o, done_res_o,
//         |     |                         | status_o, payload_length_o
//
// One input word per cycle while the output is not stalled; a result word passes through
// the token queue and then the output register.
// The front end matches the prefix and tags each byte; the back end does the
// length accumulate and payload count, one token per cycle unless the output stalls.
// Reset clears the parser state, the queue and the output valid; payload regs are not reset.
// An output stall fills the two-entry queue, then drops in_ready_o; prefix bytes and
// the colon, unless last, make no token and only wait when the queue is full.
module ipd_frame_header_parser_top import ipd_pkg::*; #(
  parameter int unsigned MAX_MESSAGE = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      data_byte_i,
  input  logic            last_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      payload_byte_o,
  output logic            payload_valid_o,
  output logic            done_res_o,
  output logic [1:0]      status_o,
  output logic [LenW-1:0] payload_length_o
);

  ipd_tok_t push_tok, pop_tok;
  logic     push, full, empty, pop;
  logic     accept;

  // held off whenever the queue is full, so no word is lost
  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  ipd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .accept_i    (accept),
    .push_o      (push),
    .tok_o       (push_tok)
  );

  ipd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .pop_tok_o  (pop_tok)
  );

  ipd_back #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .tok_i            (pop_tok),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_byte_o   (payload_byte_o),
    .payload_valid_o  (payload_valid_o),
    .done_res_o       (done_res_o),
    .status_o         (status_o),
    .payload_length_o (payload_length_o)
  );

endmodule

// File: design/ipd_front.sv
module ipd_front import ipd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_i,
  input  logic       accept_i,
  output logic       push_o,
  output ipd_tok_t   tok_o
);

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_LENGTH,
    PH_PAYLOAD
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [2:0] idx_q, idx_d;
  logic       bad_q, bad_d;
  tok_kind_e  kind;

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    bad_d   = bad_q;
    kind    = TK_NONE;
    if (bad_q) begin
      bad_d = 1'b1;
    end else begin
      unique case (phase_q)
        PH_PREFIX: begin
          if ({29'd0, idx_q} < PrefixLen && data_byte_i == prefix_byte(idx_q)) begin
            idx_d = idx_q + 3'd1;
            if ({29'd0, idx_d} == PrefixLen) phase_d = PH_LENGTH;
          end else begin
            bad_d = 1'b1;
          end
        end
        PH_LENGTH: begin
          if (data_byte_i == ColonChar) phase_d = PH_PAYLOAD;
          else                          kind    = TK_DIGIT;
        end
        PH_PAYLOAD: kind = TK_PAYLOAD;
        default:    bad_d = 1'b1;
      endcase
    end
  end

  always_comb begin
    tok_o.data = data_byte_i;
    tok_o.kind = kind;
    tok_o.last = last_i;
    if (bad_d || phase_d == PH_PREFIX) tok_o.cls = CL_BAD;
    else if (phase_d == PH_LENGTH)     tok_o.cls = CL_NOCOLON;
    else                               tok_o.cls = CL_CHECK;
  end

  // prefix bytes and the colon leave nothing for the back end unless last
  assign push_o = in_valid_i && (kind != TK_NONE || last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      idx_q   <= 3'd0;
      bad_q   <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        phase_q <= PH_PREFIX;
        idx_q   <= 3'd0;
        bad_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        bad_q   <= bad_d;
      end
    end
  end

  a_idx_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!bad_q && phase_q != PH_PREFIX) |-> ({29'd0, idx_q} == PrefixLen))
    else $error("prefix index not complete past prefix phase");

endmodule

// File: design/ipd_queue.sv
module ipd_queue import ipd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ipd_tok_t push_tok_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output ipd_tok_t pop_tok_o
);

  ipd_tok_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o    = cnt_q == QCntW'(QDepth);
  assign empty_o   = cnt_q == '0;
  assign pop_tok_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= push_tok_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + QPtrW'(1);
      if (pop_i && !empty_o) rd_q <= rd_q + QPtrW'(1);
      unique case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   cnt_q <= cnt_q + QCntW'(1);
        2'b01:   cnt_q <= cnt_q - QCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count past depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == QCntW'(QDepth)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");

endmodule

// File: design/ipd_back.sv
module ipd_back import ipd_pkg::*; #(
  parameter int unsigned MAX_MESSAGE = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  ipd_tok_t        tok_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      payload_byte_o,
  output logic            payload_valid_o,
  output logic            done_res_o,
  output logic [1:0]      status_o,
  output logic [LenW-1:0] payload_length_o
);

  localparam int unsigned CountCap = (MAX_MESSAGE > CountFieldMax) ? CountFieldMax
                                                                   : MAX_MESSAGE;
  localparam int unsigned CntW = $clog2(CountCap + 1);

  logic [31:0]     acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            vld_q;
  logic [7:0]      pb_q;
  logic            pv_q, done_q;
  logic [1:0]      st_q, st_d;
  logic [LenW-1:0] len_q, len_d;
  logic            gives_result;

  assign pop_o        = !empty_i && (!vld_q || out_ready_i);
  assign gives_result = tok_i.kind == TK_PAYLOAD || tok_i.last;

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    if (tok_i.kind == TK_DIGIT) begin
      acc_d = (acc_q << 3) + (acc_q << 1) + {24'd0, tok_i.data} - {24'd0, DigitBase};
    end
    if (tok_i.kind == TK_PAYLOAD && cnt_q < CntW'(CountCap)) begin
      cnt_d = cnt_q + CntW'(1);
    end
    st_d  = StOk;
    len_d = '0;
    if (tok_i.last) begin
      unique case (tok_i.cls)
        CL_BAD:     st_d = StBadHeader;
        CL_NOCOLON: st_d = StNoColon;
        default: begin
          len_d = LenW'(cnt_d);
          st_d  = (acc_d == 32'(cnt_d)) ? StOk : StMismatch;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      vld_q <= 1'b0;
    end else begin
      // a pop only happens once the held word is gone or leaving
      vld_q <= pop_o ? gives_result : (vld_q && !out_ready_i);
      if (pop_o) begin
        if (tok_i.last) begin
          acc_q <= '0;
          cnt_q <= '0;
        end else begin
          acc_q <= acc_d;
          cnt_q <= cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && gives_result) begin
      pv_q   <= tok_i.kind == TK_PAYLOAD;
      pb_q   <= (tok_i.kind == TK_PAYLOAD) ? tok_i.data : 8'd0;
      done_q <= tok_i.last;
      st_q   <= st_d;
      len_q  <= len_d;
    end
  end

  assign out_valid_o      = vld_q;
  assign payload_byte_o   = pb_q;
  assign payload_valid_o  = pv_q;
  assign done_res_o       = done_q;
  assign status_o         = st_q;
  assign payload_length_o = len_q;

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (pv_q || done_q))
    else $error("result word with neither payload nor done");

  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && (!done_q || st_q == StBadHeader || st_q == StNoColon)) |-> (len_q == '0))
    else $error("length reported without a checked payload");

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CountCap))
    else $error("payload count past cap");

endmodule

// File: bench/ipd_frame_header_parser_top_test.sv
module ipd_frame_header_parser_top_test;
  import ipd_pkg::*;

  // Block size under test; the payload count saturates at the smaller of this
  // and the width limit of the length field.
  localparam int unsigned MaxMsg   = 1024;
  localparam int unsigned CountCap = (MaxMsg > CountFieldMax) ? CountFieldMax : MaxMsg;

  // CR LF + I P D , packed first byte highest
  localparam logic [8*PrefixLen-1:0] HdrStr = 56'h0D0A2B4950442C;

  typedef enum logic [1:0] {
    SEEK_PREFIX,
    READ_LENGTH,
    PASS_PAYLOAD,
    PHASE_SPARE
  } parse_phase_e;

  // one result word, field by field
  typedef struct packed {
    logic [7:0]      pbyte;
    logic            pvalid;
    logic            done;
    logic [1:0]      status;
    logic [LenW-1:0] plen;
  } ipd_res_t;

  // directed stimulus row; typed rows carry the expected word written out by hand
  typedef struct packed {
    logic [7:0] d;
    logic       l;
    logic       typed;
    ipd_res_t   want;
  } dir_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [7:0]      data_byte_i = 8'h00;
  logic            last_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [7:0]      payload_byte_o;
  logic            payload_valid_o;
  logic            done_res_o;
  logic [1:0]      status_o;
  logic [LenW-1:0] payload_length_o;

  ipd_frame_header_parser_top #(
    .MAX_MESSAGE(MaxMsg)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .payload_byte_o  (payload_byte_o),
    .payload_valid_o (payload_valid_o),
    .done_res_o      (done_res_o),
    .status_o        (status_o),
    .payload_length_o(payload_length_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Hard stop, far past the slowest legal run.
  initial begin
    #2000000;
    $display("ipd_frame_header_parser_top_test NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser model: own copy of the header parser state.
  // ---------------------------------------------------------------------------
  parse_phase_e    cur_phase;
  logic [2:0]      hdr_idx;
  logic            hdr_bad;
  logic [31:0]     decl_len;     // declared length, wraps at 32 bits
  logic [LenW-1:0] pay_cnt;      // saturating payload count

  ipd_res_t parse_results_due[$];  // expected result words, oldest first
  bit       failed = 1'b0;
  bit       idle_on = 1'b1;        // random idling on both sides
  int       worked = 0;            // words the parser actually acts on

  function automatic logic [7:0] hdr_char(input int unsigned i);
    return HdrStr[8*(PrefixLen-1-i) +: 8];
  endfunction

  function automatic void clear_parser();
    cur_phase = SEEK_PREFIX;
    hdr_idx   = 3'd0;
    hdr_bad   = 1'b0;
    decl_len  = 32'd0;
    pay_cnt   = '0;
  endfunction

  // Advances the model by one byte; returns 1 if the byte yields a result word.
  function automatic bit parse_byte(input logic [7:0] b, input logic is_last,
                                    output ipd_res_t r);
    r = '0;
    if (cur_phase == SEEK_PREFIX && !hdr_bad) begin
      if (32'(hdr_idx) < PrefixLen && b == hdr_char(32'(hdr_idx))) begin
        hdr_idx = hdr_idx + 3'd1;
        if (32'(hdr_idx) == PrefixLen) cur_phase = READ_LENGTH;
      end else begin
        hdr_bad = 1'b1;
      end
    end else if (cur_phase == READ_LENGTH && !hdr_bad) begin
      // no digit check: any non-colon byte folds in as byte - '0'
      if (b == ColonChar) cur_phase = PASS_PAYLOAD;
      else decl_len = decl_len * 32'd10 + (32'(b) - 32'(DigitBase));
    end else if (cur_phase == PASS_PAYLOAD && !hdr_bad) begin
      r.pvalid = 1'b1;
      r.pbyte  = b;
      if (32'(pay_cnt) < CountCap) pay_cnt = pay_cnt + LenW'(1);
    end else begin
      hdr_bad = 1'b1;
    end

    if (is_last) begin
      r.done = 1'b1;
      if (hdr_bad || cur_phase == SEEK_PREFIX) begin
        r.status = StBadHeader;
      end else if (cur_phase == READ_LENGTH) begin
        r.status = StNoColon;
      end else begin
        r.plen   = pay_cnt;
        r.status = (decl_len == 32'(pay_cnt)) ? StOk : StMismatch;
      end
    end
    parse_byte = r.pvalid || is_last;
    if (is_last) clear_parser();
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one word per call, optional idle burst ahead of it.
  // Valid stays up across back-to-back words; only one NBA per signal per edge.
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [7:0] d, input logic l, input logic typed,
                           input ipd_res_t want);
    ipd_res_t got;
    int       gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (!hdr_bad) worked++;
    if (parse_byte(d, l, got)) parse_results_due.push_back(typed ? want : got);
    in_valid_i  <= 1'b1;
    data_byte_i <= d;
    last_i      <= l;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic dir_row_t dir_row(input logic [7:0] d, input logic l,
                                       input logic typed, input logic [7:0] pb,
                                       input logic pv, input logic [1:0] st,
                                       input logic [LenW-1:0] plen);
    dir_row_t row;
    row.d           = d;
    row.l           = l;
    row.typed       = typed;
    row.want.pbyte  = pb;
    row.want.pvalid = pv;
    row.want.done   = l;
    row.want.status = st;
    row.want.plen   = plen;
    return row;
  endfunction

  // One random message. Most are well formed with random content; the rest
  // are truncated or corrupted headers, missing colons and plain noise.
  task automatic random_message(input bit big);
    logic [7:0]  msg[$];
    logic [7:0]  digs[$];
    logic [7:0]  b;
    logic [31:0] decl;
    int          kind, plen, sel, n, j;
    kind = big ? 0 : $urandom_range(0, 99);
    if (kind < 70) begin
      for (int i = 0; i < PrefixLen; i++) msg.push_back(hdr_char(i));
      plen = big ? $urandom_range(1021, 1030) : $urandom_range(0, 24);
      sel  = $urandom_range(0, 19);
      if (big) begin
        decl = $urandom_range(0, 1) ? 32'd1024 : 32'(plen);
        sel  = 0;
      end else if (sel < 12) begin
        decl = 32'(plen);
      end else begin
        decl = $urandom_range(0, 30);
      end
      if (sel < 16) begin
        // decimal text; zero may also be sent as no digits at all
        if ($urandom_range(0, 7) == 0) msg.push_back(DigitBase);
        if (decl != 0 || $urandom_range(0, 1) == 0) begin
          do begin
            digs.push_front(DigitBase + 8'(decl % 10));
            decl = decl / 10;
          end while (decl != 0);
          foreach (digs[i]) msg.push_back(digs[i]);
        end
      end else if (sel < 18) begin
        // long digit run, the accumulator wraps
        n = $urandom_range(10, 14);
        repeat (n) msg.push_back(DigitBase + 8'($urandom_range(0, 9)));
      end else begin
        // junk in the length field
        n = $urandom_range(1, 3);
        repeat (n) begin
          do b = 8'($urandom); while (b == ColonChar);
          msg.push_back(b);
        end
      end
      msg.push_back(ColonChar);
      repeat (plen) msg.push_back(8'($urandom));
    end else if (kind < 80) begin
      // header then length text, never a colon
      for (int i = 0; i < PrefixLen; i++) msg.push_back(hdr_char(i));
      n = $urandom_range(0, 4);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) begin
          b = DigitBase + 8'($urandom_range(0, 9));
        end else begin
          do b = 8'($urandom); while (b == ColonChar);
        end
        msg.push_back(b);
      end
    end else if (kind < 85) begin
      // short message, every byte of it matching
      n = $urandom_range(1, PrefixLen - 1);
      for (int i = 0; i < n; i++) msg.push_back(hdr_char(i));
    end else if (kind < 92) begin
      // one prefix byte wrong, random tail
      for (int i = 0; i < PrefixLen; i++) msg.push_back(hdr_char(i));
      j = $urandom_range(0, PrefixLen - 1);
      do b = 8'($urandom); while (b == msg[j]);
      msg[j] = b;
      n = $urandom_range(0, 6);
      repeat (n) msg.push_back(8'($urandom));
      n = $urandom_range(j + 1, msg.size());
      while (msg.size() > n) void'(msg.pop_back());
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) msg.push_back(8'($urandom));
    end
    foreach (msg[i]) push_word(msg[i], i == msg.size() - 1, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready held low in random bursts while idling is on.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Result checker: every accepted word against the oldest expectation.
  ipd_res_t due_word;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parse_results_due.size() == 0) begin
        $display("%0t: word with none expected: byte %0h pv %0b done %0b st %0d len %0d",
                 $time, payload_byte_o, payload_valid_o, done_res_o, status_o,
                 payload_length_o);
        failed = 1'b1;
      end else begin
        due_word = parse_results_due.pop_front();
        check_field("payload_byte", 32'(due_word.pbyte), 32'(payload_byte_o));
        check_field("payload_valid", 32'(due_word.pvalid), 32'(payload_valid_o));
        check_field("done_res", 32'(due_word.done), 32'(done_res_o));
        check_field("status", 32'(due_word.status), 32'(status_o));
        check_field("payload_length", 32'(due_word.plen), 32'(payload_length_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [23];
  bit       big_pending = 1'b1;
  bit       big;

  initial begin
    clear_parser();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_tab = '{
      // lone CR: short message, bad header
      dir_row(8'h0D, 1'b1, 1'b1, 8'h00, 1'b0, StBadHeader, '0),
      // mismatch on the third byte, rest ignored; extreme byte values
      dir_row(8'h0D, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h0A, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b0, StBadHeader, '0),
      // full prefix ending on the comma: no colon
      dir_row(8'h0D, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h0A, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h2B, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h49, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h50, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h44, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h2C, 1'b1, 1'b1, 8'h00, 1'b0, StNoColon, '0),
      // "+IPD,2:" with two payload bytes at the extremes: ok
      dir_row(8'h0D, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h0A, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h2B, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h49, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h50, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h44, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h2C, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'h32, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(ColonChar, 1'b0, 1'b0, 8'h00, 1'b0, StOk, '0),
      dir_row(8'hFF, 1'b0, 1'b1, 8'hFF, 1'b1, StOk, '0),
      dir_row(8'h00, 1'b1, 1'b1, 8'h00, 1'b1, StOk, 11'd2)
    };
    foreach (dir_tab[i]) begin
      push_word(dir_tab[i].d, dir_tab[i].l, dir_tab[i].typed, dir_tab[i].want);
    end

    // Random part; one big message sized around the cap may drive the count into saturation.
    // The tail runs with no idling on either side.
    while (worked < 1750) begin
      big = big_pending && worked > 500;
      if (big) big_pending = 1'b0;
      idle_on = (worked < 1500) && ($urandom_range(0, 3) != 0);
      random_message(big);
    end
    in_valid_i <= 1'b0;

    while (parse_results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("ipd_frame_header_parser_top_test OK");
    end else begin
      $display("ipd_frame_header_parser_top_test NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
design/ipd_pkg.sv
design/ipd_front.sv
design/ipd_queue.sv
design/ipd_back.sv
design/ipd_frame_header_parser_top.sv
bench/ipd_frame_header_parser_top_test.sv
